// ===== src/dltq_pkg.sv =====
// dltq_pkg: types, sizes and codes shared by the delta list timer queue
// depends on nothing
package dltq_pkg;

	localparam int MAX_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CW          = $clog2(MAX_TIMERS + 1);
	localparam int IW          = $clog2(MAX_TIMERS);
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	typedef logic [15:0]   id_t;
	typedef logic [31:0]   us_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [NW-1:0] nres_t;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_STARTED   = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_CANCELLED = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_EXPIRED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_MERGE,
		OP_SUB
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		cnt_t     pos;
		id_t      id;
		us_t      val;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_TICK,
		S_SPREAD
	} state_t;

endpackage

// ===== src/dltq_cell.sv =====
// dltq_cell: one entry of the delta list, id and delta
// depends on dltq_pkg; shifts with its neighbors on a broadcast command
module dltq_cell (
	input  logic               clk,
	input  dltq_pkg::cnt_t     idx,
	input  dltq_pkg::cell_cmd_t cmd,
	input  dltq_pkg::id_t      left_id,
	input  dltq_pkg::us_t      left_delta,
	input  dltq_pkg::id_t      right_id,
	input  dltq_pkg::us_t      right_delta,
	output dltq_pkg::id_t      id,
	output dltq_pkg::us_t      delta
);

	dltq_pkg::id_t id_q;
	dltq_pkg::us_t delta_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			dltq_pkg::OP_INSERT: begin
				if (idx > cmd.pos) begin
					id_q <= left_id;
					// entry pushed right just past the new one gives up its share
					delta_q <= (idx == cmd.pos + 1'b1) ? left_delta - cmd.val : left_delta;
				end else if (idx == cmd.pos) begin
					id_q    <= cmd.id;
					delta_q <= cmd.val;
				end
			end
			dltq_pkg::OP_REMOVE, dltq_pkg::OP_MERGE: begin
				if (idx >= cmd.pos) begin
					id_q <= right_id;
					if (idx == cmd.pos && cmd.op == dltq_pkg::OP_MERGE) begin
						delta_q <= right_delta + delta_q;
					end else begin
						delta_q <= right_delta;
					end
				end
			end
			dltq_pkg::OP_SUB: begin
				if (idx == cmd.pos) begin
					delta_q <= delta_q - cmd.val;
				end
			end
			default: begin
			end
		endcase
	end

	assign id    = id_q;
	assign delta = delta_q;

endmodule

// ===== src/delta_list_timer_queue.sv =====
// delta_list_timer_queue: top level with the sequencer and the row of cells
// depends on dltq_pkg and dltq_cell
//
// Timers sit in a row of cells sorted by expiry, each cell holding an id and its
// time beyond the cell before it. One word is taken at a time; in_stall is high
// while a word is in work. A start passes each entry that expires no later
// than it before inserting; a cancel takes out the matching entry without
// a walk; a tick expires ids from the head, then charges the leftover time
// down the remaining entries. The sequencer walks the
// row one cell per cycle; each step that emits a result also waits for the
// output register to be free. Results leave through one output register, and
// the last word caused by an input carries last = 1. Ticks that expire nothing
// give no result. No clearing pass is needed after reset.
module delta_list_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] timer_id,
	input  logic [31:0] interval_us,
	input  logic [31:0] elapsed_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] result_id,
	output logic        last
);

	localparam int N = dltq_pkg::MAX_TIMERS;

	dltq_pkg::state_t  state_q, state_n;
	dltq_pkg::action_t action_q;
	dltq_pkg::cnt_t    count_q, count_n;
	dltq_pkg::cnt_t    pos_q, pos_n;
	dltq_pkg::id_t     req_id_q;
	dltq_pkg::us_t     rest_q, rest_n;
	dltq_pkg::nres_t   nres_q, nres_n;

	logic              out_valid_q;
	dltq_pkg::status_t out_status_q;
	dltq_pkg::id_t     out_id_q;
	logic              out_last_q;

	dltq_pkg::cell_cmd_t cmd;
	logic                emit;
	dltq_pkg::status_t   emit_status;
	dltq_pkg::id_t       emit_id;
	logic                emit_last;

	dltq_pkg::id_t cell_id [N];
	dltq_pkg::us_t cell_delta [N];

	// the row of cells
	for (genvar k = 0; k < N; k++) begin : g_cell
		dltq_pkg::id_t lid, rid;
		dltq_pkg::us_t ldl, rdl;
		if (k == 0) begin : g_first
			assign lid = '0;
			assign ldl = '0;
		end else begin : g_mid_l
			assign lid = cell_id[k-1];
			assign ldl = cell_delta[k-1];
		end
		if (k == N - 1) begin : g_end
			assign rid = '0;
			assign rdl = '0;
		end else begin : g_mid_r
			assign rid = cell_id[k+1];
			assign rdl = cell_delta[k+1];
		end
		dltq_cell u_cell (
			.clk         (clk),
			.idx         (dltq_pkg::CW'(k)),
			.cmd         (cmd),
			.left_id     (lid),
			.left_delta  (ldl),
			.right_id    (rid),
			.right_delta (rdl),
			.id          (cell_id[k]),
			.delta       (cell_delta[k])
		);
	end

	// id search over the occupied cells
	logic           any_match;
	dltq_pkg::cnt_t match_pos;
	always_comb begin
		any_match = 1'b0;
		match_pos = '0;
		for (int k = N - 1; k >= 0; k--) begin
			if (dltq_pkg::CW'(k) < count_q && cell_id[k] == req_id_q) begin
				any_match = 1'b1;
				match_pos = dltq_pkg::CW'(k);
			end
		end
	end

	logic          out_free;
	dltq_pkg::us_t cur_delta, take;
	logic          walk_on, expire_on, more_expire, spread_on;

	assign out_free  = !out_valid_q || !out_stall;
	assign cur_delta = cell_delta[pos_q[dltq_pkg::IW-1:0]];
	assign take      = (rest_q < cur_delta) ? rest_q : cur_delta;
	assign walk_on   = (pos_q < count_q) && (rest_q >= cur_delta);
	assign expire_on = (count_q != '0) && (nres_q < dltq_pkg::NW'(dltq_pkg::MAX_RESULTS))
		&& (rest_q >= cell_delta[0]);
	// would the next round expire again after this one
	assign more_expire = (count_q > dltq_pkg::CW'(1))
		&& (nres_q + 1'b1 < dltq_pkg::NW'(dltq_pkg::MAX_RESULTS))
		&& (rest_q - cell_delta[0] >= cell_delta[1]);
	assign spread_on = (pos_q < count_q) && (rest_q != '0);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			dltq_pkg::S_IDLE: begin
				if (in_valid) begin
					priority case (dltq_pkg::action_t'(action))
						dltq_pkg::ACT_START, dltq_pkg::ACT_CANCEL: state_n = dltq_pkg::S_CHECK;
						dltq_pkg::ACT_TICK:                        state_n = dltq_pkg::S_TICK;
						default:                                   state_n = dltq_pkg::S_IDLE;
					endcase
				end
			end
			dltq_pkg::S_CHECK: begin
				if (action_q == dltq_pkg::ACT_START && !any_match
					&& count_q < dltq_pkg::CW'(N)) begin
					state_n = dltq_pkg::S_WALK;
				end else if (out_free) begin
					state_n = dltq_pkg::S_IDLE;
				end
			end
			dltq_pkg::S_WALK: begin
				if (!walk_on && out_free) state_n = dltq_pkg::S_IDLE;
			end
			dltq_pkg::S_TICK: begin
				if (!expire_on) state_n = dltq_pkg::S_SPREAD;
			end
			dltq_pkg::S_SPREAD: begin
				if (!spread_on) state_n = dltq_pkg::S_IDLE;
			end
			default: state_n = dltq_pkg::S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		cmd         = '{op: dltq_pkg::OP_HOLD, pos: pos_q, id: req_id_q, val: rest_q};
		emit        = 1'b0;
		emit_status = dltq_pkg::STAT_STARTED;
		emit_id     = req_id_q;
		emit_last   = 1'b1;
		count_n     = count_q;
		pos_n       = pos_q;
		rest_n      = rest_q;
		nres_n      = nres_q;
		unique case (state_q)
			dltq_pkg::S_IDLE: begin
				pos_n  = '0;
				nres_n = '0;
				rest_n = (dltq_pkg::action_t'(action) == dltq_pkg::ACT_TICK) ? elapsed_us
					: interval_us;
			end
			dltq_pkg::S_CHECK: begin
				if (action_q == dltq_pkg::ACT_START) begin
					// duplicate check comes before the full check
					if (any_match) begin
						emit        = out_free;
						emit_status = dltq_pkg::STAT_DUPLICATE;
					end else if (count_q >= dltq_pkg::CW'(N)) begin
						emit        = out_free;
						emit_status = dltq_pkg::STAT_FULL;
					end
				end else if (out_free) begin
					emit = 1'b1;
					if (any_match) begin
						emit_status = dltq_pkg::STAT_CANCELLED;
						cmd.op      = dltq_pkg::OP_MERGE;
						cmd.pos     = match_pos;
						count_n     = count_q - 1'b1;
					end else begin
						emit_status = dltq_pkg::STAT_NOT_FOUND;
					end
				end
			end
			dltq_pkg::S_WALK: begin
				if (walk_on) begin
					pos_n  = pos_q + 1'b1;
					rest_n = rest_q - cur_delta;
				end else if (out_free) begin
					// equal times land after the existing entries
					cmd.op  = dltq_pkg::OP_INSERT;
					count_n = count_q + 1'b1;
					emit    = 1'b1;
				end
			end
			dltq_pkg::S_TICK: begin
				if (expire_on && out_free) begin
					emit        = 1'b1;
					emit_status = dltq_pkg::STAT_EXPIRED;
					emit_id     = cell_id[0];
					emit_last   = !more_expire;
					cmd.op      = dltq_pkg::OP_REMOVE;
					cmd.pos     = '0;
					count_n     = count_q - 1'b1;
					nres_n      = nres_q + 1'b1;
					rest_n      = rest_q - cell_delta[0];
				end
			end
			dltq_pkg::S_SPREAD: begin
				// leftover time charged down the row, one cell a cycle
				if (spread_on) begin
					cmd.op  = dltq_pkg::OP_SUB;
					cmd.val = take;
					rest_n  = rest_q - take;
					pos_n   = pos_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dltq_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_n;
		rest_q <= rest_n;
		nres_q <= nres_n;
		if (state_q == dltq_pkg::S_IDLE && in_valid) begin
			action_q <= dltq_pkg::action_t'(action);
			req_id_q <= timer_id;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_id_q     <= emit_id;
			out_last_q   <= emit_last;
		end
	end

	assign in_stall  = (state_q != dltq_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign result_id = out_id_q;
	assign last      = out_last_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dltq_pkg::CW'(N))
		else $error("entry count beyond capacity");

	a_expire_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dltq_pkg::S_TICK && emit) |=> count_q == $past(count_q) - 1'b1)
		else $error("expiry did not remove the head entry");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result overwrote a stalled word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for the delta list timer queue
// depends on dltq_pkg and delta_list_timer_queue
module tb;

	typedef struct {
		dltq_pkg::status_t st;
		dltq_pkg::id_t     id;
		logic              lst;
	} timer_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [15:0] timer_id;
	logic [31:0] interval_us;
	logic [31:0] elapsed_us;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] result_id;
	logic        last;

	delta_list_timer_queue uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .timer_id(timer_id),
		.interval_us(interval_us), .elapsed_us(elapsed_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_id(result_id), .last(last)
	);

	// shadow copy of the delta list
	dltq_pkg::id_t  q_ids[dltq_pkg::MAX_TIMERS];
	dltq_pkg::us_t  q_deltas[dltq_pkg::MAX_TIMERS];
	int             q_count;

	// expected results, oldest first
	timer_result_t pending_results[$];

	int   mismatches;
	int   words_sent;
	int   results_seen;
	int   expiries_seen;
	bit   send_gaps;      // random idle bursts on the sender
	bit   recv_gaps;      // random stall bursts on the receiver
	int   hold_cycles;    // long receiver hold-off, set by the pressure test

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int find_timer(dltq_pkg::id_t id);
		for (int i = 0; i < q_count; i++)
			if (q_ids[i] == id)
				return i;
		return -1;
	endfunction

	// work out the results of one word and update the shadow list
	task automatic predict_timers(dltq_pkg::action_t act, dltq_pkg::id_t id,
		dltq_pkg::us_t ival, dltq_pkg::us_t el);
		timer_result_t r;
		int pos;
		int n;
		dltq_pkg::us_t rest;
		dltq_pkg::us_t take;
		n = 0;
		r.id = id;
		r.lst = 1'b1;
		unique case (act)
			dltq_pkg::ACT_START: begin
				if (find_timer(id) >= 0)
					r.st = dltq_pkg::STAT_DUPLICATE;
				else if (q_count >= dltq_pkg::MAX_TIMERS)
					r.st = dltq_pkg::STAT_FULL;
				else begin
					// walk past every entry expiring at the same time or earlier
					pos = 0;
					rest = ival;
					while (pos < q_count && rest >= q_deltas[pos]) begin
						rest -= q_deltas[pos];
						pos++;
					end
					for (int j = q_count; j > pos; j--) begin
						q_ids[j] = q_ids[j-1];
						q_deltas[j] = q_deltas[j-1];
					end
					q_ids[pos] = id;
					q_deltas[pos] = rest;
					q_count++;
					if (pos + 1 < q_count)
						q_deltas[pos+1] -= rest;
					r.st = dltq_pkg::STAT_STARTED;
				end
				pending_results.push_back(r);
			end
			dltq_pkg::ACT_CANCEL: begin
				pos = find_timer(id);
				if (pos < 0)
					r.st = dltq_pkg::STAT_NOT_FOUND;
				else begin
					// the removed delta moves on to the next entry
					if (pos + 1 < q_count)
						q_deltas[pos+1] += q_deltas[pos];
					for (int j = pos; j + 1 < q_count; j++) begin
						q_ids[j] = q_ids[j+1];
						q_deltas[j] = q_deltas[j+1];
					end
					q_count--;
					r.st = dltq_pkg::STAT_CANCELLED;
				end
				pending_results.push_back(r);
			end
			dltq_pkg::ACT_TICK: begin
				// expire from the head, at most MAX_RESULTS per tick
				while (q_count > 0 && n < dltq_pkg::MAX_RESULTS && el >= q_deltas[0]) begin
					el -= q_deltas[0];
					r.st = dltq_pkg::STAT_EXPIRED;
					r.id = q_ids[0];
					r.lst = 1'b0;
					pending_results.push_back(r);
					n++;
					for (int j = 0; j + 1 < q_count; j++) begin
						q_ids[j] = q_ids[j+1];
						q_deltas[j] = q_deltas[j+1];
					end
					q_count--;
				end
				if (n > 0)
					pending_results[$].lst = 1'b1;
				// leftover time is charged down the list
				for (int j = 0; j < q_count && el > 0; j++) begin
					take = (el < q_deltas[j]) ? el : q_deltas[j];
					q_deltas[j] -= take;
					el -= take;
				end
			end
			default: ;
		endcase
	endtask

	// offer one word and hold it until accepted
	task automatic send_word(dltq_pkg::action_t act, dltq_pkg::id_t id,
		dltq_pkg::us_t ival, dltq_pkg::us_t el);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			action <= 2'($urandom_range(0, 3));
			timer_id <= 16'($urandom);
			interval_us <= $urandom;
			elapsed_us <= $urandom;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		predict_timers(act, id, ival, el);
		in_valid <= 1'b1;
		action <= act;
		timer_id <= id;
		interval_us <= ival;
		elapsed_us <= el;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// receiver stall: long hold-off first, else random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12) - 1) @(posedge clk);
			end else
				out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		timer_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (status == dltq_pkg::STAT_EXPIRED)
				expiries_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d id %0h last %0b",
						status, result_id, last);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || result_id !== e.id || last !== e.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp status %0d id %0h last %0b, got %0d %0h %0b",
							e.st, e.id, e.lst, status, result_id, last);
				end
			end
		end
	end

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * dltq_pkg::MAX_TIMERS + 8) @(posedge clk);
	endtask

	// edges of fields, every action, every special case
	task automatic test_directed();
		send_word(dltq_pkg::ACT_CANCEL, 16'h0000, 32'h0, 32'h0);     // cancel on empty list
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);  // tick on empty list
		send_word(dltq_pkg::ACT_START, 16'h0000, 32'h0, 32'h0);      // zero interval
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'h0);          // zero tick expires it
		send_word(dltq_pkg::ACT_START, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
		send_word(dltq_pkg::ACT_START, 16'h1234, 32'd100, 32'h0);
		send_word(dltq_pkg::ACT_START, 16'h4321, 32'd100, 32'h0);    // equal time goes after
		send_word(dltq_pkg::ACT_START, 16'h1234, 32'd5, 32'h0);      // duplicate
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'd40);         // nothing expires
		send_word(dltq_pkg::ACT_CANCEL, 16'h1234, 32'h0, 32'h0);     // delta moves on
		send_word(dltq_pkg::ACT_CANCEL, 16'h7777, 32'h0, 32'h0);     // absent id
		send_word(dltq_pkg::ACT_NONE, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA);
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'd60);
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
		wait_drain();
	endtask

	// fill the list, hit full and duplicate, then expire all in one tick
	task automatic test_full_list();
		for (int i = 0; i < dltq_pkg::MAX_TIMERS; i++)
			send_word(dltq_pkg::ACT_START, dltq_pkg::id_t'(16'h100 + i),
				dltq_pkg::us_t'($urandom_range(0, 50)), 32'h0);
		send_word(dltq_pkg::ACT_START, 16'h0100, 32'd1, 32'h0);      // duplicate beats full
		send_word(dltq_pkg::ACT_START, 16'h0EEE, 32'd1, 32'h0);      // full
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'd1000);       // sixteen expiries
		wait_drain();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 24; i++)
			send_word(dltq_pkg::ACT_START, dltq_pkg::id_t'($urandom_range(0, 31)),
				dltq_pkg::us_t'($urandom_range(0, 200)), 32'h0);
		send_word(dltq_pkg::ACT_TICK, 16'h0, 32'h0, 32'd10000);
		wait_drain();
	endtask

	// mostly small ids and times so starts, cancels and ticks meet
	task automatic test_random(int n_words);
		int sel;
		dltq_pkg::us_t v;
		for (int i = 0; i < n_words; i++) begin
			sel = $urandom_range(0, 99);
			v = ($urandom_range(0, 9) == 0) ? dltq_pkg::us_t'($urandom)
				: dltq_pkg::us_t'($urandom_range(0, 400));
			if (sel < 45)
				send_word(dltq_pkg::ACT_START, ($urandom_range(0, 9) == 0)
					? dltq_pkg::id_t'($urandom)
					: dltq_pkg::id_t'($urandom_range(0, 40)), v, $urandom);
			else if (sel < 65)
				send_word(dltq_pkg::ACT_CANCEL, ($urandom_range(0, 9) == 0)
					? dltq_pkg::id_t'($urandom)
					: dltq_pkg::id_t'($urandom_range(0, 40)), $urandom, $urandom);
			else if (sel < 97)
				send_word(dltq_pkg::ACT_TICK, dltq_pkg::id_t'($urandom), $urandom,
					($urandom_range(0, 15) == 0) ? dltq_pkg::us_t'($urandom) :
					dltq_pkg::us_t'($urandom_range(0, 150)));
			else
				send_word(dltq_pkg::ACT_NONE, dltq_pkg::id_t'($urandom), $urandom, $urandom);
		end
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = dltq_pkg::ACT_NONE;
		timer_id = '0;
		interval_us = '0;
		elapsed_us = '0;
		q_count = 0;
		mismatches = 0;
		words_sent = 0;
		results_seen = 0;
		expiries_seen = 0;
		hold_cycles = 0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		test_backpressure();
		test_random(200);
		// last part runs without idling on either side
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		test_random(80);
		$display("run covered %0d words in, %0d words out, %0d of them expiries",
			words_sent, results_seen, expiries_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== delta_list_timer_queue.f =====
src/dltq_pkg.sv
src/dltq_cell.sv
src/delta_list_timer_queue.sv
tb/tb.sv
